// ===== rtl/core/bgt_pkg.sv =====
// Package with shared codes and types for the button gesture trigger.
package bgt_pkg;

  localparam int unsigned MAG_W = 16;
  localparam int unsigned DT_W = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PARM_W = 32;
  localparam int unsigned CNT_W = 16;

  localparam logic [2:0] MODE_PRESSED = 3'd0;
  localparam logic [2:0] MODE_RELEASED = 3'd1;
  localparam logic [2:0] MODE_DOWN = 3'd2;
  localparam logic [2:0] MODE_HOLD = 3'd3;
  localparam logic [2:0] MODE_HOLD_REL = 3'd4;
  localparam logic [2:0] MODE_TAP = 3'd5;
  localparam logic [2:0] MODE_PULSE = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SHOT = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TIME = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ON_START = 4'd7;

  localparam logic [1:0] TS_NONE = 2'd0;
  localparam logic [1:0] TS_ONGOING = 2'd1;
  localparam logic [1:0] TS_TRIGGERED = 2'd2;
  localparam logic [1:0] TS_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

// ===== rtl/core/button_gesture_trigger.sv =====
// Top level of the button gesture trigger with its sequencer and serial remainder unit.
// One sample is taken when the block is idle; it passes through capture, evaluation and the
// hand-off to the output register, which waits while the output is stalled, and in pulse mode
// a press time above a nonzero interval also passes through the one-bit-per-cycle restoring
// remainder unit. The result register decouples the output, so a new sample is taken while a result still waits.
module button_gesture_trigger #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned MAG_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bgt_pkg::MAG_W-1:0]       in_magnitude,
  input  logic [bgt_pkg::DT_W-1:0]        in_elapsed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_trigger_state,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bgt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bgt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned MW = (MAG_BITS < bgt_pkg::MAG_W) ? MAG_BITS : bgt_pkg::MAG_W;
  localparam int unsigned SW = ((TIME_BITS > bgt_pkg::DT_W) ? TIME_BITS : bgt_pkg::DT_W) + 1;
  localparam int unsigned CW = (TIME_BITS > bgt_pkg::PARM_W) ? TIME_BITS : bgt_pkg::PARM_W;
  localparam int unsigned DCW = $clog2(TIME_BITS);
  localparam int unsigned PW = bgt_pkg::PARM_W;

  bgt_pkg::state_t state_r, state_nxt;

  logic [2:0]                mode_r;
  logic [bgt_pkg::MAG_W-1:0] thr_r;
  logic [PW-1:0]             hold_r;
  logic                      one_shot_r;
  logic [PW-1:0]             tap_r;
  logic [PW-1:0]             intv_r;
  logic [bgt_pkg::CNT_W-1:0] lim_r;
  logic                      on_start_r;

  logic                      was_act_r, was_act_nxt;
  logic [TIME_BITS-1:0]      press_r, press_nxt;
  logic                      fired_r, fired_nxt;
  logic [bgt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]             rem_r, rem_nxt;
  logic [DCW-1:0]            dcnt_r, dcnt_nxt;
  logic [1:0]                res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_ts_r, out_ts_nxt;

  logic [bgt_pkg::MAG_W-1:0] mag_r;
  logic [bgt_pkg::DT_W-1:0]  dt_r;

  logic                 act;
  logic [SW-1:0]        sum_w;
  logic [TIME_BITS-1:0] sat_time;
  logic                 pulse;
  logic [PW:0]          div_t;
  logic                 div_ge;
  logic                 out_free;

  assign in_stall = (state_r != bgt_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_trigger_state = out_ts_r;
  assign out_free = !out_valid_r || !out_stall;

  assign act = mag_r[MW-1:0] >= thr_r[MW-1:0];
  assign sum_w = SW'(press_r) + SW'(dt_r);
  assign sat_time = (sum_w[SW-1:TIME_BITS] != '0) ? {TIME_BITS{1'b1}} : sum_w[TIME_BITS-1:0];
  assign div_t = {rem_r, press_r[TIME_BITS-1]};
  assign div_ge = div_t >= {1'b0, intv_r};

  always_comb begin
    state_nxt = state_r;
    was_act_nxt = was_act_r;
    press_nxt = press_r;
    fired_nxt = fired_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    out_ts_nxt = out_ts_r;
    pulse = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      bgt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = bgt_pkg::S_EVAL;
        end
      end
      bgt_pkg::S_EVAL: begin
        state_nxt = bgt_pkg::S_OUT;
        was_act_nxt = act;
        res_nxt = bgt_pkg::TS_NONE;
        case (mode_r)
          bgt_pkg::MODE_PRESSED: begin
            res_nxt = (!was_act_r && act) ? bgt_pkg::TS_TRIGGERED : bgt_pkg::TS_NONE;
          end
          bgt_pkg::MODE_RELEASED: begin
            res_nxt = act ? bgt_pkg::TS_ONGOING :
                      (was_act_r ? bgt_pkg::TS_TRIGGERED : bgt_pkg::TS_NONE);
          end
          bgt_pkg::MODE_DOWN: begin
            res_nxt = act ? bgt_pkg::TS_TRIGGERED : bgt_pkg::TS_NONE;
          end
          bgt_pkg::MODE_HOLD: begin
            if (act) begin
              press_nxt = sat_time;
              if (CW'(sat_time) < CW'(hold_r)) begin
                res_nxt = bgt_pkg::TS_ONGOING;
              end else if (!one_shot_r) begin
                res_nxt = bgt_pkg::TS_TRIGGERED;
              end else begin
                res_nxt = fired_r ? bgt_pkg::TS_NONE : bgt_pkg::TS_TRIGGERED;
                fired_nxt = 1'b1;
              end
            end else begin
              press_nxt = '0;
              fired_nxt = 1'b0;
            end
          end
          bgt_pkg::MODE_HOLD_REL: begin
            if (act) begin
              press_nxt = sat_time;
              res_nxt = bgt_pkg::TS_ONGOING;
            end else if (press_r != '0) begin
              press_nxt = '0;
              res_nxt = bgt_pkg::TS_TRIGGERED;
            end
          end
          bgt_pkg::MODE_TAP: begin
            if (act) begin
              press_nxt = sat_time;
              res_nxt = bgt_pkg::TS_ONGOING;
            end else begin
              res_nxt = (was_act_r && (CW'(press_r) <= CW'(tap_r))) ?
                        bgt_pkg::TS_TRIGGERED : bgt_pkg::TS_NONE;
              press_nxt = '0;
            end
          end
          bgt_pkg::MODE_PULSE: begin
            if (act) begin
              if (cnt_r < lim_r) begin
                pulse = on_start_r && !was_act_r;
                press_nxt = sat_time;
                if (CW'(sat_time) > CW'(intv_r)) begin
                  pulse = 1'b1;
                  if (intv_r == '0) begin
                    press_nxt = '0;
                  end else begin
                    state_nxt = bgt_pkg::S_DIV;
                    rem_nxt = '0;
                    dcnt_nxt = DCW'(TIME_BITS - 1);
                  end
                end
                if (pulse) begin
                  cnt_nxt = cnt_r + 1'b1;
                  res_nxt = bgt_pkg::TS_TRIGGERED;
                end else begin
                  res_nxt = bgt_pkg::TS_ONGOING;
                end
              end
            end else begin
              press_nxt = '0;
              cnt_nxt = '0;
            end
          end
          default: begin
            res_nxt = bgt_pkg::TS_NONE;
          end
        endcase
      end
      bgt_pkg::S_DIV: begin
        rem_nxt = div_ge ? PW'(div_t - {1'b0, intv_r}) : div_t[PW-1:0];
        press_nxt = {press_r[TIME_BITS-2:0], 1'b0};
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          press_nxt = TIME_BITS'(rem_nxt);
          state_nxt = bgt_pkg::S_OUT;
        end
      end
      bgt_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ts_nxt = res_r;
          state_nxt = bgt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bgt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bgt_pkg::S_IDLE;
      was_act_r <= 1'b0;
      press_r <= '0;
      fired_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      mode_r <= bgt_pkg::MODE_PRESSED;
      thr_r <= 16'h8000;
      hold_r <= '0;
      one_shot_r <= 1'b0;
      tap_r <= '0;
      intv_r <= 32'd1;
      lim_r <= '0;
      on_start_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      was_act_r <= was_act_nxt;
      press_r <= press_nxt;
      fired_r <= fired_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bgt_pkg::REG_MODE: mode_r <= cfg_data[2:0];
          bgt_pkg::REG_THRESHOLD: thr_r <= cfg_data[bgt_pkg::MAG_W-1:0];
          bgt_pkg::REG_HOLD_TIME: hold_r <= cfg_data;
          bgt_pkg::REG_ONE_SHOT: one_shot_r <= cfg_data[0];
          bgt_pkg::REG_TAP_TIME: tap_r <= cfg_data;
          bgt_pkg::REG_INTERVAL: intv_r <= cfg_data;
          bgt_pkg::REG_LIMIT: lim_r <= cfg_data[bgt_pkg::CNT_W-1:0];
          bgt_pkg::REG_ON_START: on_start_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    res_r <= res_nxt;
    out_ts_r <= out_ts_nxt;
    if (in_valid && !in_stall) begin
      mag_r <= in_magnitude;
      dt_r <= in_elapsed;
    end
  end

endmodule

// ===== rtl/core/bgt_check.sv =====
// Port-level checker for the button gesture trigger and its bind.
module bgt_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_trigger_state
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall)
    else $error("Block took a new request too soon after an accepted one.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_trigger_state)))
    else $error("Stalled result changed or was dropped.");

  a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_trigger_state != bgt_pkg::TS_UNUSED))
    else $error("Result carries an unused trigger state code.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("Block is not idle after reset.");

endmodule

bind button_gesture_trigger bgt_check u_bgt_check (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_trigger_state(out_trigger_state)
);

// ===== sim/button_gesture_trigger_test.sv =====
// Self-checking testbench for the button gesture trigger with a trigger state predictor.
`timescale 1ns / 1ps

module button_gesture_trigger_test;

  localparam int unsigned MAG_W = bgt_pkg::MAG_W;
  localparam int unsigned DT_W = bgt_pkg::DT_W;
  localparam int unsigned CFG_IDX_W = bgt_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = bgt_pkg::CFG_DATA_W;
  localparam int unsigned CNT_W = bgt_pkg::CNT_W;

  localparam logic [2:0] MODE_RESERVED = 3'd7;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
  localparam int unsigned RANDOM_SAMPLES = 1700;
  localparam int unsigned STEADY_SAMPLES = 150;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 64;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MAG_W-1:0] in_magnitude = '0;
  logic [DT_W-1:0] in_elapsed = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_trigger_state;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies, at their reset values.
  logic [2:0] mode_reg = bgt_pkg::MODE_PRESSED;
  logic [MAG_W-1:0] threshold_reg = 16'd32768;
  logic [31:0] hold_time_reg = '0;
  logic one_shot_reg = 1'b0;
  logic [31:0] tap_time_reg = '0;
  logic [31:0] interval_reg = 32'd1;
  logic [CNT_W-1:0] limit_reg = '0;
  logic on_start_reg = 1'b1;

  logic was_pressed = 1'b0;
  logic [31:0] press_time = '0;
  logic hold_fired = 1'b0;
  logic [CNT_W-1:0] pulse_count = '0;

  logic [1:0] expected_states[$];
  int unsigned samples_sent = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  logic steady = 1'b0;
  int unsigned hold_off_asked = 0;
  int unsigned hold_off_seen = 0;
  int unsigned hold_off_left = 0;

  button_gesture_trigger i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_magnitude      (in_magnitude),
    .in_elapsed        (in_elapsed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger_state (out_trigger_state),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("button_gesture_trigger_test failed");
    $finish;
  end

  function automatic logic [31:0] time_sum(input logic [31:0] t, input logic [DT_W-1:0] d);
    logic [32:0] s;
    s = {1'b0, t} + {17'b0, d};
    return s[32] ? TIME_MAX : s[31:0];
  endfunction

  function automatic logic [1:0] next_trigger_state(input logic [MAG_W-1:0] mag,
                                                    input logic [DT_W-1:0] dt);
    logic act;
    logic prev;
    logic pulse;
    logic [1:0] res;
    act = mag >= threshold_reg;
    prev = was_pressed;
    res = bgt_pkg::TS_NONE;
    case (mode_reg)
      bgt_pkg::MODE_PRESSED: begin
        res = (!prev && act) ? bgt_pkg::TS_TRIGGERED : bgt_pkg::TS_NONE;
      end
      bgt_pkg::MODE_RELEASED: begin
        res = act ? bgt_pkg::TS_ONGOING :
              (prev ? bgt_pkg::TS_TRIGGERED : bgt_pkg::TS_NONE);
      end
      bgt_pkg::MODE_DOWN: res = act ? bgt_pkg::TS_TRIGGERED : bgt_pkg::TS_NONE;
      bgt_pkg::MODE_HOLD: begin
        if (act) begin
          press_time = time_sum(press_time, dt);
          if (press_time < hold_time_reg) begin
            res = bgt_pkg::TS_ONGOING;
          end else if (!one_shot_reg) begin
            res = bgt_pkg::TS_TRIGGERED;
          end else begin
            res = hold_fired ? bgt_pkg::TS_NONE : bgt_pkg::TS_TRIGGERED;
            hold_fired = 1'b1;
          end
        end else begin
          press_time = '0;
          hold_fired = 1'b0;
        end
      end
      bgt_pkg::MODE_HOLD_REL: begin
        if (act) begin
          press_time = time_sum(press_time, dt);
          res = bgt_pkg::TS_ONGOING;
        end else if (press_time != 0) begin
          press_time = '0;
          res = bgt_pkg::TS_TRIGGERED;
        end
      end
      bgt_pkg::MODE_TAP: begin
        if (act) begin
          press_time = time_sum(press_time, dt);
          res = bgt_pkg::TS_ONGOING;
        end else begin
          if (prev && press_time <= tap_time_reg) res = bgt_pkg::TS_TRIGGERED;
          press_time = '0;
        end
      end
      bgt_pkg::MODE_PULSE: begin
        if (!act) begin
          press_time = '0;
          pulse_count = '0;
        end else if (pulse_count < limit_reg) begin
          pulse = on_start_reg && !prev;
          press_time = time_sum(press_time, dt);
          if (press_time > interval_reg) begin
            pulse = 1'b1;
            press_time = (interval_reg == 0) ? '0 : press_time % interval_reg;
          end
          if (pulse) begin
            pulse_count = pulse_count + 1'b1;
            res = bgt_pkg::TS_TRIGGERED;
          end else begin
            res = bgt_pkg::TS_ONGOING;
          end
        end
      end
      default: res = bgt_pkg::TS_NONE;
    endcase
    was_pressed = act;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_states.push_back(next_trigger_state(in_magnitude, in_elapsed));
    end
  end

  always @(posedge clk) begin
    logic [1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_states.size() == 0) begin
        $error("trigger_state %0d arrived with no request waiting", out_trigger_state);
        errors++;
      end else begin
        want = expected_states.pop_front();
        if (out_trigger_state !== want) begin
          $error("trigger_state: expected %0d, actual %0d", want, out_trigger_state);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off_seen != hold_off_asked) begin
      hold_off_seen <= hold_off_asked;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 30);
    end
  end

  task automatic send_sample(input logic [MAG_W-1:0] mag, input logic [DT_W-1:0] dt);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_magnitude <= mag;
    in_elapsed <= dt;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (results_seen < samples_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bgt_pkg::REG_MODE: mode_reg = data[2:0];
      bgt_pkg::REG_THRESHOLD: threshold_reg = data[MAG_W-1:0];
      bgt_pkg::REG_HOLD_TIME: hold_time_reg = data;
      bgt_pkg::REG_ONE_SHOT: one_shot_reg = data[0];
      bgt_pkg::REG_TAP_TIME: tap_time_reg = data;
      bgt_pkg::REG_INTERVAL: interval_reg = data;
      bgt_pkg::REG_LIMIT: limit_reg = data[CNT_W-1:0];
      bgt_pkg::REG_ON_START: on_start_reg = data[0];
      default: ;
    endcase
  endtask

  // Narrow registers get random upper bits, which the block must drop. The last write
  // goes to an unused index and must change nothing.
  task automatic configure(input logic [2:0] mode, input logic [MAG_W-1:0] thr,
                           input logic [31:0] hold, input logic one_shot,
                           input logic [31:0] tap, input logic [31:0] interval,
                           input logic [CNT_W-1:0] limit, input logic on_start);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[2:0] = mode;
    write_reg(bgt_pkg::REG_MODE, data);
    data = $urandom;
    data[MAG_W-1:0] = thr;
    write_reg(bgt_pkg::REG_THRESHOLD, data);
    write_reg(bgt_pkg::REG_HOLD_TIME, hold);
    data = $urandom;
    data[0] = one_shot;
    write_reg(bgt_pkg::REG_ONE_SHOT, data);
    write_reg(bgt_pkg::REG_TAP_TIME, tap);
    write_reg(bgt_pkg::REG_INTERVAL, interval);
    data = $urandom;
    data[CNT_W-1:0] = limit;
    write_reg(bgt_pkg::REG_LIMIT, data);
    data = $urandom;
    data[0] = on_start;
    write_reg(bgt_pkg::REG_ON_START, data);
    write_reg(CFG_IDX_W'($urandom_range(8, 15)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MAG_W-1:0] press_level(input logic [MAG_W-1:0] thr);
    return MAG_W'($urandom_range(65535, thr));
  endfunction

  function automatic logic [MAG_W-1:0] rest_level(input logic [MAG_W-1:0] thr);
    return (thr == 0) ? MAG_W'($urandom) : MAG_W'($urandom_range(0, thr - 1));
  endfunction

  task automatic test_reset_values();
    send_sample(16'd32767, 16'd0);
    send_sample(16'd32768, 16'hFFFF);
    send_sample(16'hFFFF, 16'd1);
    send_sample(16'd0, 16'd0);
    wait_results();
  endtask

  task automatic test_directed_cases();
    configure(bgt_pkg::MODE_RELEASED, 16'hFFFF, 32'd0, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    send_sample(16'hFFFF, 16'd0);
    send_sample(16'hFFFE, 16'd0);
    wait_results();
    configure(bgt_pkg::MODE_DOWN, 16'd0, 32'd0, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    send_sample(16'd0, 16'd0);
    wait_results();
    configure(bgt_pkg::MODE_HOLD, 16'd1, 32'd100, 1'b1, 32'd0, 32'd1, 16'd0, 1'b0);
    send_sample(16'd1, 16'd60);
    send_sample(16'd1, 16'd40);
    send_sample(16'hFFFF, 16'd0);
    send_sample(16'd0, 16'd0);
    wait_results();
    configure(bgt_pkg::MODE_HOLD_REL, 16'd1, 32'd0, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    send_sample(16'd1, 16'd0);
    send_sample(16'd0, 16'd0);
    send_sample(16'd1, 16'd5);
    send_sample(16'd0, 16'd0);
    wait_results();
    configure(bgt_pkg::MODE_TAP, 16'd1, 32'd0, 1'b0, 32'd10, 32'd1, 16'd0, 1'b0);
    send_sample(16'd1, 16'd10);
    send_sample(16'd0, 16'd0);
    send_sample(16'd1, 16'd11);
    send_sample(16'd0, 16'd0);
    wait_results();
    // A zero interval pulses on any nonzero press time; the limit then stops the pulses.
    configure(bgt_pkg::MODE_PULSE, 16'd1, 32'd0, 1'b0, 32'd0, 32'd0, 16'd3, 1'b1);
    send_sample(16'd1, 16'd0);
    send_sample(16'd1, 16'd0);
    send_sample(16'd1, 16'd1);
    send_sample(16'd1, 16'hFFFF);
    send_sample(16'd1, 16'd5);
    send_sample(16'd0, 16'd0);
    wait_results();
    configure(bgt_pkg::MODE_PULSE, 16'd1, 32'd0, 1'b0, 32'd0, TIME_MAX, 16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF);
    wait_results();
    configure(MODE_RESERVED, 16'd1, 32'd0, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'd0, 16'd0);
    wait_results();
  endtask

  // One long press sent with no idling on either side, crossing the hold time midway,
  // then a tap judged against the largest tap time.
  task automatic test_steady_stream();
    int unsigned i;
    steady <= 1'b1;
    configure(bgt_pkg::MODE_HOLD, 16'd1, 32'd5_000_000, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    for (i = 0; i < STEADY_SAMPLES; i++) begin
      send_sample(MAG_W'($urandom_range(1, 65535)), 16'hFFFF);
    end
    wait_results();
    configure(bgt_pkg::MODE_TAP, 16'd1, 32'd0, 1'b0, TIME_MAX, 32'd1, 16'd0, 1'b0);
    send_sample(16'd1, 16'hFFFF);
    send_sample(16'd0, 16'd0);
    wait_results();
    steady <= 1'b0;
  endtask

  task automatic test_backpressure();
    int unsigned i;
    configure(bgt_pkg::MODE_PULSE, 16'h8000, 32'd0, 1'b0, 32'd0, 32'd7, 16'hFFFF, 1'b1);
    hold_off_asked <= hold_off_asked + 1;
    for (i = 0; i < 40; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        send_sample(press_level(16'h8000), DT_W'($urandom_range(0, 20)));
      end else begin
        send_sample(rest_level(16'h8000), DT_W'($urandom_range(0, 20)));
      end
    end
    wait_results();
  endtask

  task automatic test_random_phases();
    int unsigned first;
    int unsigned phase_start;
    int unsigned phase_len;
    int unsigned p;
    int unsigned i;
    int unsigned press_len;
    int unsigned dt_max;
    int unsigned span;
    logic extreme;
    logic [MAG_W-1:0] thr;
    logic [31:0] hold;
    logic [31:0] tap;
    logic [31:0] interval;
    logic [CNT_W-1:0] limit;
    first = samples_sent;
    p = 0;
    while (samples_sent - first < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 3))
        0: dt_max = 3;
        1: dt_max = 40;
        2: dt_max = 1000;
        default: dt_max = 65535;
      endcase
      span = dt_max * 6;
      extreme = (p % 5 == 4);
      if (extreme) begin
        thr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        hold = $urandom_range(0, 1) ? TIME_MAX : 32'd0;
        tap = $urandom_range(0, 1) ? TIME_MAX : 32'd0;
        case ($urandom_range(0, 2))
          0: interval = 32'd0;
          1: interval = 32'd1;
          default: interval = TIME_MAX;
        endcase
        limit = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end else begin
        thr = MAG_W'($urandom_range(1, 65535));
        hold = $urandom_range(0, span);
        tap = $urandom_range(0, span);
        interval = $urandom_range(1, span);
        limit = CNT_W'($urandom_range(0, 8));
      end
      configure(3'(p % 8), thr, hold, 1'($urandom), tap, interval, limit, 1'($urandom));
      phase_start = samples_sent;
      phase_len = $urandom_range(60, 110);
      while (samples_sent - phase_start < phase_len) begin
        if ($urandom_range(0, 99) < 85) begin
          press_len = $urandom_range(1, 12);
          for (i = 0; i < press_len; i++) begin
            send_sample(press_level(thr), DT_W'($urandom_range(0, dt_max)));
          end
          press_len = $urandom_range(1, 2);
          for (i = 0; i < press_len; i++) begin
            send_sample(rest_level(thr), DT_W'($urandom_range(0, dt_max)));
          end
        end else begin
          send_sample(MAG_W'($urandom), DT_W'($urandom));
        end
      end
      wait_results();
      p++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_cases();
    test_steady_stream();
    test_backpressure();
    test_random_phases();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_states.size() != 0) begin
      $error("%0d trigger_state results never arrived", expected_states.size());
      errors++;
    end
    if (errors == 0) begin
      $display("button_gesture_trigger_test passed");
    end else begin
      $display("button_gesture_trigger_test failed");
    end
    $finish;
  end

endmodule
